// ===== hw/rtl/refcounted_page_frame_allocator_unit_defines.svh =====
// assertion macros used by the allocator sequencer
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication on clk, quiet during rst
`define RPFA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication on clk, quiet during rst
`define RPFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rpfa_pkg.sv =====
// shared constants and types of the page frame allocator
package rpfa_pkg;

  localparam int unsigned ADDR_W     = 25;
  localparam int unsigned PADDR_W    = 32;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned BASE_PAGE  = 256;

  localparam logic [ADDR_W-1:0]  BASE_ADDR   = 25'h0100000;
  localparam logic [ADDR_W-1:0]  END_RESET   = 25'h1100000;
  localparam logic [COUNT_W-1:0] USED_COUNT  = 8'd100;
  localparam logic [COUNT_W-1:0] MAX_COUNT   = 8'd255;

  localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
  localparam logic [OP_W-1:0] OP_SHARE = 3'd2;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd3;
  localparam logic [OP_W-1:0] OP_INIT  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOPAGE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREEFREE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SAT      = 3'd5;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_FREE_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEM_END    = 2'd1;

  typedef struct packed {
    logic [COUNT_W-1:0]  ref_count;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_address;
  } res_t;

endpackage

// ===== hw/rtl/rpfa_count_ram.sv =====
// reference count memory, one write and one registered read port
module rpfa_count_ram #(
  parameter int NUM_PAGES = 4096,
  localparam int IDXW = $clog2(NUM_PAGES)
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [IDXW-1:0]                  waddr,
  input  logic [rpfa_pkg::COUNT_W-1:0]     wdata,
  input  logic [IDXW-1:0]                  raddr,
  output logic [rpfa_pkg::COUNT_W-1:0]     rdata
);

  logic [rpfa_pkg::COUNT_W-1:0] mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rpfa_seq.sv =====
// sequencer: range check, count update, allocate scan and map sweep
`include "refcounted_page_frame_allocator_unit_defines.svh"

module rpfa_seq #(
  parameter int NUM_PAGES = 4096,
  localparam int IDXW = $clog2(NUM_PAGES)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rpfa_pkg::OP_W-1:0]        in_op,
  input  logic [rpfa_pkg::PADDR_W-1:0]     in_addr,
  input  logic [rpfa_pkg::ADDR_W-1:0]      start_addr,
  input  logic [rpfa_pkg::ADDR_W-1:0]      end_addr,
  output logic                             mem_we,
  output logic [IDXW-1:0]                  mem_waddr,
  output logic [rpfa_pkg::COUNT_W-1:0]     mem_wdata,
  output logic [IDXW-1:0]                  mem_raddr,
  input  logic [rpfa_pkg::COUNT_W-1:0]     mem_rdata,
  output logic                             res_valid,
  input  logic                             res_ready,
  output rpfa_pkg::res_t                   res
);

  localparam int CMPW = ((IDXW > 14) ? IDXW : 14) + 1;
  localparam int PNW  = rpfa_pkg::PADDR_W - rpfa_pkg::PAGE_SHIFT;
  localparam int PGW  = rpfa_pkg::ADDR_W - rpfa_pkg::PAGE_SHIFT;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_PAGES - 1);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_LOCATE,
    S_MODIFY,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                          state;
  logic [rpfa_pkg::OP_W-1:0]       op;
  logic [rpfa_pkg::PADDR_W-1:0]    addr;
  logic [IDXW-1:0]                 idx;
  logic                            rd_pend;
  logic [IDXW-1:0]                 rd_tag;
  logic                            free_en;
  logic                            report;
  logic [PGW-1:0]                  lo;
  logic [PGW:0]                    hi;

  logic                            below;
  logic                            beyond;
  logic [PNW-1:0]                  off;
  logic [CMPW-1:0]                 page_num;
  logic                            free_here;
  logic                            found;
  logic                            scan_oom;
  logic [rpfa_pkg::ADDR_W-1:0]     diff;
  logic [rpfa_pkg::PADDR_W-1:0]    alloc_addr;
  logic [rpfa_pkg::COUNT_W-1:0]    new_cnt;
  logic [rpfa_pkg::STATUS_W-1:0]   mod_status;
  logic                            mod_we;

  // range check of the latched page address
  assign below  = (addr[rpfa_pkg::PADDR_W-1:20] == '0);
  assign off    = addr[rpfa_pkg::PADDR_W-1:rpfa_pkg::PAGE_SHIFT] - PNW'(rpfa_pkg::BASE_PAGE);
  assign beyond = (addr >= rpfa_pkg::PADDR_W'(end_addr)) ||
                  ({1'b0, off} >= (PNW+1)'(NUM_PAGES));

  // init sweep window in page numbers
  assign diff      = end_addr - start_addr;
  assign page_num  = CMPW'(idx) + CMPW'(rpfa_pkg::BASE_PAGE);
  assign free_here = free_en && (page_num >= CMPW'(lo)) && (page_num < CMPW'(hi));

  // allocate scan, one read issued per cycle, checked in the cycle after
  assign found      = (state == S_SCAN) && rd_pend && (mem_rdata == '0);
  assign scan_oom   = (state == S_SCAN) && rd_pend && (mem_rdata != '0) && (rd_tag == '0);
  assign alloc_addr = rpfa_pkg::PADDR_W'(rpfa_pkg::BASE_ADDR) +
                      rpfa_pkg::PADDR_W'({rd_tag, {rpfa_pkg::PAGE_SHIFT{1'b0}}});

  always_comb begin
    new_cnt    = mem_rdata;
    mod_status = rpfa_pkg::ST_OK;
    mod_we     = 1'b0;
    case (op)
      rpfa_pkg::OP_FREE: begin
        if (mem_rdata != '0) begin
          new_cnt = mem_rdata - 8'd1;
          mod_we  = 1'b1;
        end else begin
          mod_status = rpfa_pkg::ST_FREEFREE;
        end
      end
      rpfa_pkg::OP_SHARE: begin
        if (mem_rdata != rpfa_pkg::MAX_COUNT) begin
          new_cnt = mem_rdata + 8'd1;
          mod_we  = 1'b1;
        end else begin
          mod_status = rpfa_pkg::ST_SAT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = free_here ? '0 : rpfa_pkg::USED_COUNT;
    case (state)
      S_SWEEP: mem_we = 1'b1;
      S_SCAN: begin
        mem_we    = found;
        mem_waddr = rd_tag;
        mem_wdata = 8'd1;
      end
      S_MODIFY: begin
        mem_we    = mod_we;
        mem_wdata = new_cnt;
      end
      default: begin
      end
    endcase
  end

  assign mem_raddr = (state == S_LOCATE) ? off[IDXW-1:0] : idx;
  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SWEEP;
      idx     <= '0;
      free_en <= 1'b0;
      report  <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      case (state)
        S_SWEEP: begin
          if (idx == LAST_IDX) begin
            state <= report ? S_DONE : S_IDLE;
            res   <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op   <= in_op;
            addr <= in_addr;
            res  <= '0;
            case (in_op)
              rpfa_pkg::OP_ALLOC: begin
                state   <= S_SCAN;
                idx     <= LAST_IDX;
                rd_pend <= 1'b0;
              end
              rpfa_pkg::OP_FREE, rpfa_pkg::OP_SHARE, rpfa_pkg::OP_QUERY: begin
                state <= S_LOCATE;
              end
              rpfa_pkg::OP_INIT: begin
                state   <= S_SWEEP;
                idx     <= '0;
                report  <= 1'b1;
                free_en <= (end_addr > start_addr);
                lo      <= start_addr[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT];
                hi      <= {1'b0, start_addr[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT]} +
                           {1'b0, diff[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT]};
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_LOCATE: begin
          if (below) begin
            res.status <= rpfa_pkg::ST_BELOW;
            state      <= S_DONE;
          end else if (beyond) begin
            res.status <= rpfa_pkg::ST_NOPAGE;
            state      <= S_DONE;
          end else begin
            idx   <= off[IDXW-1:0];
            state <= S_MODIFY;
          end
        end
        S_MODIFY: begin
          res.status    <= mod_status;
          res.ref_count <= new_cnt;
          state         <= S_DONE;
        end
        S_SCAN: begin
          if (found) begin
            res.result_address <= alloc_addr[rpfa_pkg::ADDR_W-1:0];
            res.status         <= rpfa_pkg::ST_OK;
            res.ref_count      <= 8'd1;
            state              <= S_DONE;
          end else if (scan_oom) begin
            res.status <= rpfa_pkg::ST_OOM;
            state      <= S_DONE;
          end else begin
            rd_pend <= 1'b1;
            rd_tag  <= idx;
            idx     <= idx - 1'b1;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state  <= S_IDLE;
            report <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RPFA_ASSERT_NOW(a_write_states, mem_we, (state == S_SWEEP) || (state == S_SCAN) || (state == S_MODIFY), "count write outside sweep, scan or update")
  `RPFA_ASSERT_NEXT(a_alloc_result, found, (state == S_DONE) && (res.status == rpfa_pkg::ST_OK) && (res.ref_count == 8'd1), "allocate hit did not give count one")
  `RPFA_ASSERT_NOW(a_query_no_write, (state == S_MODIFY) && (op == rpfa_pkg::OP_QUERY), !mem_we, "query changed a count")

endmodule

// ===== hw/rtl/refcounted_page_frame_allocator_unit.sv =====
// Page frame allocator keeping an 8-bit reference count per 4 KiB page above
// the 1 MiB base, all counts held in one single-port-read memory. Requests
// are taken one at a time. Free, share and query pass through range check
// with count read, update and hand-off to the output register; a rejected
// address skips the update. Allocate walks the counts from the top page
// down, one memory read per cycle; init rewrites every count, one per
// cycle. After reset a clearing pass sets every count to 100, with s_tready
// low; configuration writes are taken throughout. A finished result waits
// in the output register while the next request is accepted.
module refcounted_page_frame_allocator_unit #(
  parameter int NUM_PAGES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // page_address[31:0]
  input  logic [2:0]  s_tuser,   // operation[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // result_address[24:0], ref_count[32:25], zero[39:33]
  output logic [2:0]  m_tuser,   // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [rpfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rpfa_pkg::ADDR_W-1:0]      cfg_data
);

  localparam int IDXW = $clog2(NUM_PAGES);

  logic [rpfa_pkg::ADDR_W-1:0]  start_addr;
  logic [rpfa_pkg::ADDR_W-1:0]  end_addr;
  logic                         mem_we;
  logic [IDXW-1:0]              mem_waddr;
  logic [rpfa_pkg::COUNT_W-1:0] mem_wdata;
  logic [IDXW-1:0]              mem_raddr;
  logic [rpfa_pkg::COUNT_W-1:0] mem_rdata;
  logic                         res_valid;
  logic                         res_ready;
  rpfa_pkg::res_t               res;
  rpfa_pkg::res_t               out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_addr <= rpfa_pkg::BASE_ADDR;
      end_addr   <= rpfa_pkg::END_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpfa_pkg::REG_FREE_START: start_addr <= cfg_data;
        rpfa_pkg::REG_MEM_END:    end_addr   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rpfa_count_ram #(.NUM_PAGES(NUM_PAGES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rpfa_seq #(.NUM_PAGES(NUM_PAGES)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_op      (s_tuser),
    .in_addr    (s_tdata),
    .start_addr (start_addr),
    .end_addr   (end_addr),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
      if (res_valid) begin
        out <= res;
      end
    end
  end

  assign m_tdata = {7'd0, out.ref_count, out.result_address};
  assign m_tuser = out.status;

endmodule

// ===== test/refcounted_page_frame_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the reference-counted page frame allocator
module refcounted_page_frame_allocator_unit_tb;

  localparam int NUM_PAGES = 4096;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 22;
  localparam int BURST_ITEMS = 8;
  localparam int N_DIRECTED = 24;

  localparam logic [rpfa_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [rpfa_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [rpfa_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [rpfa_pkg::OP_W-1:0]     op;
    logic [rpfa_pkg::PADDR_W-1:0]  addr;
    logic                          typed_in;
    logic [rpfa_pkg::ADDR_W-1:0]   want_addr;
    logic [rpfa_pkg::STATUS_W-1:0] want_status;
    logic [rpfa_pkg::COUNT_W-1:0]  want_count;
  } directed_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [31:0]                      s_tdata = '0;
  logic [2:0]                       s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [39:0]                      m_tdata;
  logic [2:0]                       m_tuser;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [rpfa_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rpfa_pkg::ADDR_W-1:0]      cfg_data = '0;

  logic [rpfa_pkg::COUNT_W-1:0] page_count [NUM_PAGES];
  logic [rpfa_pkg::ADDR_W-1:0]  free_start;
  logic [rpfa_pkg::ADDR_W-1:0]  mem_end;
  rpfa_pkg::res_t               pending_results [$];
  logic [rpfa_pkg::ADDR_W-1:0]  live_pages [$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_seq = 0;
  int hold_seen = 0;
  int rx_hold = 0;
  int rx_gap;
  int failures = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int tally_sat = 0;
  int tally_oom = 0;
  int tally_double_free = 0;
  rpfa_pkg::res_t want;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{rpfa_pkg::OP_QUERY, 32'h0010_0000, 1'b1, 25'd0, rpfa_pkg::ST_OK, rpfa_pkg::USED_COUNT},
    '{rpfa_pkg::OP_QUERY, 32'h0000_0000, 1'b1, 25'd0, rpfa_pkg::ST_BELOW, 8'd0},
    '{rpfa_pkg::OP_QUERY, 32'h000F_FFFF, 1'b1, 25'd0, rpfa_pkg::ST_BELOW, 8'd0},
    '{rpfa_pkg::OP_QUERY, 32'hFFFF_FFFF, 1'b1, 25'd0, rpfa_pkg::ST_NOPAGE, 8'd0},
    '{rpfa_pkg::OP_QUERY, 32'h010F_FFFF, 1'b1, 25'd0, rpfa_pkg::ST_OK, rpfa_pkg::USED_COUNT},
    '{rpfa_pkg::OP_QUERY, 32'h0110_0000, 1'b1, 25'd0, rpfa_pkg::ST_NOPAGE, 8'd0},
    '{rpfa_pkg::OP_FREE,  32'h0000_0000, 1'b1, 25'd0, rpfa_pkg::ST_BELOW, 8'd0},
    '{rpfa_pkg::OP_SHARE, 32'h0110_0000, 1'b1, 25'd0, rpfa_pkg::ST_NOPAGE, 8'd0},
    '{rpfa_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, 25'd0, rpfa_pkg::ST_OOM, 8'd0},
    '{rpfa_pkg::OP_FREE,  32'h0010_0000, 1'b1, 25'd0, rpfa_pkg::ST_OK, 8'd99},
    '{rpfa_pkg::OP_SHARE, 32'h0010_0FFF, 1'b1, 25'd0, rpfa_pkg::ST_OK, rpfa_pkg::USED_COUNT},
    '{OP_SPARE_5,         32'hFFFF_FFFF, 1'b1, 25'd0, rpfa_pkg::ST_OK, 8'd0},
    '{OP_SPARE_6,         32'h0010_0000, 1'b1, 25'd0, rpfa_pkg::ST_OK, 8'd0},
    '{OP_SPARE_7,         32'h5A5A_5A5A, 1'b1, 25'd0, rpfa_pkg::ST_OK, 8'd0},
    '{rpfa_pkg::OP_INIT,  32'hA5A5_A5A5, 1'b1, 25'd0, rpfa_pkg::ST_OK, 8'd0},
    '{rpfa_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, 25'h10FF000, rpfa_pkg::ST_OK, 8'd1},
    '{rpfa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 25'h10FE000, rpfa_pkg::ST_OK, 8'd1},
    '{rpfa_pkg::OP_FREE,  32'h010F_F123, 1'b1, 25'd0, rpfa_pkg::ST_OK, 8'd0},
    '{rpfa_pkg::OP_FREE,  32'h010F_F000, 1'b1, 25'd0, rpfa_pkg::ST_FREEFREE, 8'd0},
    '{rpfa_pkg::OP_SHARE, 32'h010F_E000, 1'b0, 25'd0, rpfa_pkg::ST_OK, 8'd0},
    '{rpfa_pkg::OP_FREE,  32'h010F_EFFF, 1'b0, 25'd0, rpfa_pkg::ST_OK, 8'd0},
    '{rpfa_pkg::OP_QUERY, 32'h010F_E800, 1'b0, 25'd0, rpfa_pkg::ST_OK, 8'd0},
    '{rpfa_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, 25'd0, rpfa_pkg::ST_OK, 8'd0},
    '{rpfa_pkg::OP_SHARE, 32'h0010_0000, 1'b0, 25'd0, rpfa_pkg::ST_OK, 8'd0}
  };

  refcounted_page_frame_allocator_unit #(
    .NUM_PAGES(NUM_PAGES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic rpfa_pkg::res_t predict_request(logic [rpfa_pkg::OP_W-1:0] op,
                                                     logic [rpfa_pkg::PADDR_W-1:0] addr);
    rpfa_pkg::res_t r;
    int idx;
    int first_page;
    int run;
    r = '0;
    if (op == rpfa_pkg::OP_FREE || op == rpfa_pkg::OP_SHARE || op == rpfa_pkg::OP_QUERY) begin
      if (addr < rpfa_pkg::BASE_ADDR) begin
        r.status = rpfa_pkg::ST_BELOW;
      end else if (addr >= mem_end) begin
        r.status = rpfa_pkg::ST_NOPAGE;
      end else if (((addr - rpfa_pkg::BASE_ADDR) >> rpfa_pkg::PAGE_SHIFT) >= NUM_PAGES) begin
        r.status = rpfa_pkg::ST_NOPAGE;
      end else begin
        idx = int'((addr - rpfa_pkg::BASE_ADDR) >> rpfa_pkg::PAGE_SHIFT);
        if (op == rpfa_pkg::OP_FREE) begin
          if (page_count[idx] != '0) page_count[idx] = page_count[idx] - 1'b1;
          else r.status = rpfa_pkg::ST_FREEFREE;
        end else if (op == rpfa_pkg::OP_SHARE) begin
          if (page_count[idx] < rpfa_pkg::MAX_COUNT) page_count[idx] = page_count[idx] + 1'b1;
          else r.status = rpfa_pkg::ST_SAT;
        end
        r.ref_count = page_count[idx];
      end
    end else if (op == rpfa_pkg::OP_ALLOC) begin
      r.status = rpfa_pkg::ST_OOM;
      for (int i = NUM_PAGES - 1; i >= 0; i--) begin
        if (page_count[i] == '0) begin
          page_count[i] = 8'd1;
          r.result_address = rpfa_pkg::BASE_ADDR + (25'(i) << rpfa_pkg::PAGE_SHIFT);
          r.status = rpfa_pkg::ST_OK;
          r.ref_count = 8'd1;
          break;
        end
      end
    end else if (op == rpfa_pkg::OP_INIT) begin
      for (int j = 0; j < NUM_PAGES; j++) page_count[j] = rpfa_pkg::USED_COUNT;
      if (mem_end > free_start) begin
        first_page = int'(free_start >> rpfa_pkg::PAGE_SHIFT) - int'(rpfa_pkg::BASE_PAGE);
        run = int'((mem_end - free_start) >> rpfa_pkg::PAGE_SHIFT);
        for (int j = first_page; j < first_page + run; j++)
          if (j >= 0 && j < NUM_PAGES) page_count[j] = '0;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap(bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [rpfa_pkg::OP_W-1:0] pick_operation();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return rpfa_pkg::OP_ALLOC;
    if (roll < 47) return rpfa_pkg::OP_FREE;
    if (roll < 69) return rpfa_pkg::OP_SHARE;
    if (roll < 92) return rpfa_pkg::OP_QUERY;
    if (roll < 95) return rpfa_pkg::OP_INIT;
    return 3'($urandom_range(OP_SPARE_5, OP_SPARE_7));
  endfunction

  function automatic logic [rpfa_pkg::PADDR_W-1:0] pick_address();
    int roll;
    logic [rpfa_pkg::PADDR_W-1:0] a;
    roll = $urandom_range(0, 99);
    a = $urandom;
    if (roll < 40 && live_pages.size() != 0)
      a = 32'(live_pages[$urandom_range(0, live_pages.size() - 1)]) | (a & 32'hFFF);
    else if (roll < 75)
      a = 32'(rpfa_pkg::BASE_ADDR)
          + (32'($urandom_range(0, NUM_PAGES - 1)) << rpfa_pkg::PAGE_SHIFT)
          + (a & 32'hFFF);
    else if (roll < 83)
      a = 32'(mem_end) + 32'($urandom_range(0, 8191)) - 32'd4096;
    else if (roll < 91)
      a = a & 32'h000F_FFFF;
    return a;
  endfunction

  task automatic send_request(input logic [rpfa_pkg::OP_W-1:0] op,
                              input logic [rpfa_pkg::PADDR_W-1:0] addr,
                              input logic typed_in, input rpfa_pkg::res_t typed_result);
    int gap;
    rpfa_pkg::res_t predicted;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= addr;
    s_tuser <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_request(op, addr);
    if (op == rpfa_pkg::OP_ALLOC && predicted.status == rpfa_pkg::ST_OK) begin
      live_pages.push_back(predicted.result_address);
      if (live_pages.size() > 64) void'(live_pages.pop_front());
    end
    pending_results.push_back(typed_in ? typed_result : predicted);
    requests_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [rpfa_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [rpfa_pkg::ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == rpfa_pkg::REG_FREE_START) free_start = value;
    else if (idx == rpfa_pkg::REG_MEM_END) mem_end = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // result side: random back-pressure, long hold-off on request, field checks
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          failures++;
          $display("%0t: expected no result, got addr %h status %0d count %0d", $time,
                   m_tdata[24:0], m_tuser, m_tdata[32:25]);
        end else begin
          want = pending_results.pop_front();
          if (want.status == rpfa_pkg::ST_SAT) tally_sat++;
          if (want.status == rpfa_pkg::ST_OOM) tally_oom++;
          if (want.status == rpfa_pkg::ST_FREEFREE) tally_double_free++;
          if (m_tdata[24:0] !== want.result_address) begin
            failures++;
            $display("%0t: result_address expected %h got %h", $time,
                     want.result_address, m_tdata[24:0]);
          end
          if (m_tuser !== want.status) begin
            failures++;
            $display("%0t: status expected %0d got %0d", $time, want.status, m_tuser);
          end
          if (m_tdata[32:25] !== want.ref_count) begin
            failures++;
            $display("%0t: ref_count expected %0d got %0d", $time,
                     want.ref_count, m_tdata[32:25]);
          end
        end
      end
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        rx_hold = LONG_HOLD;
      end
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        rx_gap = pick_gap(rx_idle_on);
        if (rx_gap == 0) begin
          m_tready <= 1'b1;
        end else begin
          m_tready <= 1'b0;
          rx_hold = rx_gap - 1;
        end
      end
    end
  end

  initial begin
    logic [rpfa_pkg::ADDR_W-1:0] phase_start [PHASES];
    logic [rpfa_pkg::ADDR_W-1:0] phase_end [PHASES];
    rpfa_pkg::res_t typed;
    for (int j = 0; j < NUM_PAGES; j++) page_count[j] = rpfa_pkg::USED_COUNT;
    free_start = rpfa_pkg::BASE_ADDR;
    mem_end = rpfa_pkg::END_RESET;

    phase_start[0] = rpfa_pkg::BASE_ADDR;
    phase_end[0] = rpfa_pkg::END_RESET;
    phase_start[1] = rpfa_pkg::END_RESET;
    phase_end[1] = rpfa_pkg::BASE_ADDR;
    phase_start[2] = 25'($urandom_range(rpfa_pkg::BASE_ADDR, rpfa_pkg::END_RESET));
    phase_end[2] = phase_start[2];
    phase_start[3] = 25'($urandom_range(rpfa_pkg::BASE_ADDR, rpfa_pkg::END_RESET));
    phase_end[3] = 25'($urandom_range(rpfa_pkg::BASE_ADDR, rpfa_pkg::END_RESET));
    phase_start[4] = 25'($urandom_range(rpfa_pkg::END_RESET - 25'h40000,
                                        rpfa_pkg::END_RESET));
    phase_end[4] = rpfa_pkg::END_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      typed.result_address = directed_rows[k].want_addr;
      typed.status = directed_rows[k].want_status;
      typed.ref_count = directed_rows[k].want_count;
      send_request(directed_rows[k].op, directed_rows[k].addr,
                   directed_rows[k].typed_in, typed);
    end
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      tx_idle_on = (phase != 2);
      rx_idle_on = (phase != 2);
      write_register(rpfa_pkg::REG_FREE_START, phase_start[phase]);
      write_register(rpfa_pkg::REG_MEM_END, phase_end[phase]);
      send_request(rpfa_pkg::OP_INIT, $urandom, 1'b0, '0);
      if (phase == 0) begin
        // keep offering requests while the result side holds off
        tx_idle_on = 1'b0;
        hold_seq++;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (phase == 0 && n == BURST_ITEMS) tx_idle_on = 1'b1;
        if (phase == 3 && n == ITEMS_PER_PHASE / 2) drain_results();
        send_request(pick_operation(), pick_address(), 1'b0, '0);
      end
      drain_results();
    end

    repeat (64) @(posedge clk);
    if (pending_results.size() != 0) begin
      failures++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("checked %0d results for %0d requests over %0d register settings",
             results_checked, requests_sent, PHASES + 1);
    $display("saw %0d saturated shares, %0d out-of-memory allocates, %0d double frees",
             tally_sat, tally_oom, tally_double_free);
    if (failures == 0) begin
      $display("refcounted_page_frame_allocator_unit verification clean");
    end else begin
      $display("refcounted_page_frame_allocator_unit verification failed");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("%0t: timeout", $time);
    $display("refcounted_page_frame_allocator_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rpfa_pkg.sv
hw/rtl/rpfa_count_ram.sv
hw/rtl/rpfa_seq.sv
hw/rtl/refcounted_page_frame_allocator_unit.sv
test/refcounted_page_frame_allocator_unit_tb.sv
